// File: rtl/core/rrht_pkg.sv
// ----------------------------------------------------------------------------
// rrht_pkg
// Shared types and constants for the rectangle region hit test block.
// ----------------------------------------------------------------------------
`default_nettype none

package rrht_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = 5;
	localparam int CNT_W       = IDX_W + 1;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 8;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] top;
		logic [2:0] wid;
		logic [2:0] hgt;
		logic [3:0] typ;
	} rrht_entry_t;

	typedef struct packed {
		logic start_query;
		logic wr;
		logic clear_res;
		logic scan;
		logic capture;
		logic push;
	} rrht_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} rrht_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/rrht_ctrl.sv
// ----------------------------------------------------------------------------
// rrht_ctrl
// Sequencer: accepts an item, runs the table scan for a query and hands the result on.
// ----------------------------------------------------------------------------
`default_nettype none

module rrht_ctrl
	import rrht_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_kind,
	output logic           in_ready,
	input  rrht_sts_t      sts,
	output rrht_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == KIND_QUERY) begin
						cmd.start_query = 1'b1;
						state_d         = ST_SCAN;
					end else begin
						cmd.wr        = 1'b1;
						cmd.clear_res = 1'b1;
						state_d       = ST_PUSH;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.done) begin
					cmd.capture = 1'b1;
					state_d     = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rrht_dp.sv
// ----------------------------------------------------------------------------
// rrht_dp
// Region table, scan counter, containment test and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrht_dp
	import rrht_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  rrht_cmd_t              cmd,
	output rrht_sts_t              sts,
	input  wire logic [IDX_W-1:0]  entry_index,
	input  rrht_entry_t            wr_entry,
	input  wire logic [15:0]       point_x,
	input  wire logic [15:0]       point_y,
	input  wire logic              use_type_filter,
	input  wire logic [3:0]        want_type,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic                   out_found,
	output logic [IDX_W-1:0]       out_found_index
);

	rrht_entry_t                 mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]      vld_q;

	logic [15:0]       x_q;
	logic [15:0]       y_q;
	logic              filt_q;
	logic [3:0]        want_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              rd_issue;

	rrht_entry_t       ent_s1;
	logic              ent_vld_s1;
	logic              eval_vld_s1;
	logic [IDX_W-1:0]  eval_idx_s1;

	logic              res_found_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              out_vld_q;
	logic              out_found_q;
	logic [IDX_W-1:0]  out_idx_q;

	logic [8:0]        x1;
	logic [8:0]        y1;
	logic              in_x;
	logic              in_y;
	logic              stop;
	logic              hit;
	logic              last;

	assign rd_issue = cmd.scan && (rd_cnt_q < CNT_W'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.wr && ({1'b0, entry_index} < CNT_W'(TABLE_DEPTH))) begin
			mem[entry_index] <= wr_entry;
		end
		ent_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wr && ({1'b0, entry_index} < CNT_W'(TABLE_DEPTH))) begin
			vld_q[entry_index] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			x_q    <= point_x;
			y_q    <= point_y;
			filt_q <= use_type_filter;
			want_q <= want_type;
		end
		ent_vld_s1  <= vld_q[rd_cnt_q[IDX_W-1:0]];
		eval_idx_s1 <= rd_cnt_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			eval_vld_s1 <= 1'b0;
		end else begin
			eval_vld_s1 <= rd_issue;
			if (cmd.start_query) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
		end
	end

	// x and y are signed; a negative point is outside every region
	assign x1   = {1'b0, ent_s1.left} + {6'd0, ent_s1.wid};
	assign y1   = {1'b0, ent_s1.top} + {6'd0, ent_s1.hgt};
	assign in_x = !x_q[15] && (x_q[14:0] >= {7'd0, ent_s1.left})
		&& (x_q[14:0] < {6'd0, x1});
	assign in_y = !y_q[15] && (y_q[14:0] >= {7'd0, ent_s1.top})
		&& (y_q[14:0] < {6'd0, y1});
	assign stop = !ent_vld_s1 || (ent_s1.typ == 4'd0);
	assign hit  = !stop && in_x && in_y && (!filt_q || (ent_s1.typ == want_q));
	assign last = ({1'b0, eval_idx_s1} == CNT_W'(TABLE_DEPTH - 1));

	assign sts.done     = eval_vld_s1 && (stop || hit || last);
	assign sts.out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.clear_res) begin
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
		end else if (cmd.capture) begin
			res_found_q <= hit;
			res_idx_q   <= hit ? eval_idx_s1 : '0;
		end
		if (cmd.push) begin
			out_found_q <= res_found_q;
			out_idx_q   <= res_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.push) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign out_valid       = out_vld_q;
	assign out_found       = out_found_q;
	assign out_found_index = out_idx_q;

endmodule

`default_nettype wire

// File: rtl/core/rectangle_region_hit_test.sv
// ----------------------------------------------------------------------------
// rectangle_region_hit_test
// Table of rectangular regions with first-match point hit test.
// A write item also yields a result; a query scans N entries (at most 32),
// read from the table one entry per cycle.
// One item in flight; the next is taken once the result enters the output reg.
// Reset: asynchronous, clears control state and the table valid bits (empty).
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_region_hit_test
	import rrht_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// entry_index, left, top, width, height, region_type, point_x, point_y,
	// use_type_filter, want_type
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// kind
	input  wire logic [0:0]            s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// found, found_index
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	rrht_cmd_t         cmd;
	rrht_sts_t         sts;
	rrht_entry_t       wr_entry;
	logic              found;
	logic [IDX_W-1:0]  found_index;

	assign wr_entry.left = s_axis_tdata[12:5];
	assign wr_entry.top  = s_axis_tdata[20:13];
	assign wr_entry.wid  = s_axis_tdata[23:21];
	assign wr_entry.hgt  = s_axis_tdata[26:24];
	assign wr_entry.typ  = s_axis_tdata[30:27];

	rrht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrht_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.entry_index     (s_axis_tdata[4:0]),
		.wr_entry        (wr_entry),
		.point_x         (s_axis_tdata[46:31]),
		.point_y         (s_axis_tdata[62:47]),
		.use_type_filter (s_axis_tdata[63]),
		.want_type       (s_axis_tdata[67:64]),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_found       (found),
		.out_found_index (found_index)
	);

	assign m_axis_tdata = {2'b00, found_index, found};

endmodule

`default_nettype wire
